>>> rtl/stpool_pkg.sv
// Shared constants and types for the software timer pool.
package stpool_pkg;

  localparam int SLOT_COUNT   = 16;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int LINK_W       = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_FIELD_W = 4;
  localparam int IVAL_W       = 32;
  localparam int ELAP_W       = 32;
  localparam int TAG_W        = 16;
  localparam int TICK_W       = 16;
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 88;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_TICK   = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_ALLOC      = 3'd0,
    KIND_EMPTY      = 3'd1,
    KIND_FIRED      = 3'd2,
    KIND_TICK_DONE  = 3'd3,
    KIND_CANCEL_ACK = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_FIRE,
    ST_PRUNE,
    ST_FREE,
    ST_RESP,
    ST_DONE
  } state_e;

endpackage

>>> rtl/software_timer_pool.sv
// Timer pool: free list and active list kept in slot arrays, walked by one sequencer.
//
// Requests arrive on the s_axis channel: allocate (interval and owner tag),
// tick (milliseconds passed) or cancel (slot). Results leave on m_axis, one
// item per beat, with tlast on the final result of each request; an unused
// opcode is dropped with no result.
// Allocate and cancel give one result each: allocate passes through the alloc
// and response states, cancel goes straight to the response state. A tick
// walks the active list twice: the fire walk runs each active slot through one
// saturating adder and comparator, then the prune walk unlinks cancelled slots
// and pushes each onto the free list in the free state; the tick-done item
// follows. The next request is taken once the final result of the current one
// is loaded into the output register.
// Fired results come out in list order, then a tick-done item.
// s_axis_tready is high only while no request is in progress; a request is
// taken even when a result still waits in the output register.
// When the receiver stalls, the walk holds at the slot about to fire until
// the output register frees up; nothing is lost or reordered.
// Reset chains every slot onto the free list, leaves the active list empty
// and clears the output valid flag; it takes effect at once, with no sweep.
module software_timer_pool (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // opcode[1:0], interval_ms[33:2], owner_tag[49:34], tick_ms[65:50],
  // target_slot[69:66], zero pad
  input  logic [stpool_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // kind[2:0], slot[6:3], tag[22:7], fired_interval[54:23],
  // fired_elapsed[86:55], zero pad
  output logic [stpool_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int SW = stpool_pkg::SLOT_W;
  localparam int LW = stpool_pkg::LINK_W;
  localparam int SC = stpool_pkg::SLOT_COUNT;

  // request fields
  stpool_pkg::op_e                   in_op;
  logic [stpool_pkg::IVAL_W-1:0]     in_ival;
  logic [stpool_pkg::TAG_W-1:0]      in_tag;
  logic [stpool_pkg::TICK_W-1:0]     in_tick;
  logic [stpool_pkg::SLOT_FIELD_W-1:0] in_target;
  logic                              in_acc;

  assign in_op     = stpool_pkg::op_e'(s_axis_tdata[1:0]);
  assign in_ival   = s_axis_tdata[33:2];
  assign in_tag    = s_axis_tdata[49:34];
  assign in_tick   = s_axis_tdata[65:50];
  assign in_target = s_axis_tdata[69:66];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // control state
  stpool_pkg::state_e state_q, state_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] active_head_q, active_head_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [LW-1:0] next_q, next_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [LW-1:0] link_q [SC];
  logic [SC-1:0] active_q;

  // slot payload
  logic [stpool_pkg::IVAL_W-1:0] ival_q [SC];
  logic [stpool_pkg::ELAP_W-1:0] elap_q [SC];
  logic [stpool_pkg::TAG_W-1:0]  tag_q  [SC];

  // latched request
  logic [stpool_pkg::IVAL_W-1:0] req_ival_q;
  logic [stpool_pkg::TAG_W-1:0]  req_tag_q;
  logic [stpool_pkg::TICK_W-1:0] req_tick_q;
  stpool_pkg::kind_e             kind_q, kind_d;
  logic [SW-1:0]                 rslot_q, rslot_d;

  // output register
  logic                                  out_valid_q;
  logic [stpool_pkg::OUT_DATA_W-1:0]     out_data_q;
  logic                                  out_last_q;
  logic                                  out_free;

  // datapath
  logic [SW-1:0]   cur_idx;
  logic [SW-1:0]   rd_idx;
  logic [LW-1:0]   link_rd;
  logic            walk_end;
  logic [stpool_pkg::ELAP_W:0]   sum;
  logic [stpool_pkg::ELAP_W-1:0] sat;
  logic            fire;
  logic [LW-1:0]   target_w;

  // array write ports
  logic            link_we;
  logic [SW-1:0]   link_wa;
  logic [LW-1:0]   link_wd;
  logic            elap_we;
  logic [SW-1:0]   elap_wa;
  logic [stpool_pkg::ELAP_W-1:0] elap_wd;
  logic            alloc_we;
  logic            act_set;
  logic            act_clr;
  logic [SW-1:0]   act_clr_idx;

  // output push
  logic            push;
  logic            push_last;
  stpool_pkg::kind_e push_kind;
  logic [stpool_pkg::SLOT_FIELD_W-1:0] push_slot;
  logic [stpool_pkg::TAG_W-1:0]  push_tag;
  logic [stpool_pkg::IVAL_W-1:0] push_ival;
  logic [stpool_pkg::ELAP_W-1:0] push_elap;

  assign s_axis_tready = (state_q == stpool_pkg::ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  assign cur_idx  = cur_q[SW-1:0];
  assign rd_idx   = (state_q == stpool_pkg::ST_ALLOC) ? free_head_q[SW-1:0] : cur_idx;
  assign link_rd  = link_q[rd_idx];
  assign walk_end = (cur_q == stpool_pkg::NULL_LINK) || (steps_q == LW'(SC));
  assign target_w = LW'(in_target);

  // shared saturating adder and compare
  assign sum  = {1'b0, elap_q[cur_idx]} + (stpool_pkg::ELAP_W + 1)'(req_tick_q);
  assign sat  = sum[stpool_pkg::ELAP_W] ? '1 : sum[stpool_pkg::ELAP_W-1:0];
  assign fire = (sat >= ival_q[cur_idx]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stpool_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            stpool_pkg::OP_ALLOC:  state_d = stpool_pkg::ST_ALLOC;
            stpool_pkg::OP_TICK:   state_d = stpool_pkg::ST_FIRE;
            stpool_pkg::OP_CANCEL: state_d = stpool_pkg::ST_RESP;
            default:               state_d = stpool_pkg::ST_IDLE;
          endcase
        end
      end
      stpool_pkg::ST_ALLOC: state_d = stpool_pkg::ST_RESP;
      stpool_pkg::ST_FIRE: begin
        if (walk_end) state_d = stpool_pkg::ST_PRUNE;
      end
      stpool_pkg::ST_PRUNE: begin
        if (walk_end) begin
          state_d = stpool_pkg::ST_DONE;
        end else if (!active_q[cur_idx]) begin
          state_d = stpool_pkg::ST_FREE;
        end
      end
      stpool_pkg::ST_FREE: state_d = stpool_pkg::ST_PRUNE;
      stpool_pkg::ST_RESP, stpool_pkg::ST_DONE: begin
        if (out_free) state_d = stpool_pkg::ST_IDLE;
      end
      default: state_d = stpool_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    next_d        = next_q;
    steps_d       = steps_q;
    kind_d        = kind_q;
    rslot_d       = rslot_q;
    link_we       = 1'b0;
    link_wa       = cur_idx;
    link_wd       = free_head_q;
    elap_we       = 1'b0;
    elap_wa       = cur_idx;
    elap_wd       = sat;
    alloc_we      = 1'b0;
    act_set       = 1'b0;
    act_clr       = 1'b0;
    act_clr_idx   = in_target[SW-1:0];
    push          = 1'b0;
    push_last     = 1'b1;
    push_kind     = kind_q;
    push_slot     = stpool_pkg::SLOT_FIELD_W'(rslot_q);
    push_tag      = '0;
    push_ival     = '0;
    push_elap     = '0;
    case (state_q)
      stpool_pkg::ST_IDLE: begin
        if (in_acc) begin
          cur_d   = active_head_q;
          prev_d  = stpool_pkg::NULL_LINK;
          steps_d = '0;
          kind_d  = stpool_pkg::KIND_CANCEL_ACK;
          rslot_d = '0;
          if (in_op == stpool_pkg::OP_CANCEL && target_w < stpool_pkg::NULL_LINK) begin
            act_clr = 1'b1;
          end
        end
      end
      stpool_pkg::ST_ALLOC: begin
        if (free_head_q == stpool_pkg::NULL_LINK) begin
          kind_d  = stpool_pkg::KIND_EMPTY;
          rslot_d = '0;
        end else begin
          kind_d        = stpool_pkg::KIND_ALLOC;
          rslot_d       = free_head_q[SW-1:0];
          alloc_we      = 1'b1;
          act_set       = 1'b1;
          elap_we       = 1'b1;
          elap_wa       = free_head_q[SW-1:0];
          elap_wd       = '0;
          link_we       = 1'b1;
          link_wa       = free_head_q[SW-1:0];
          link_wd       = active_head_q;
          active_head_d = free_head_q;
          free_head_d   = link_rd;
        end
      end
      stpool_pkg::ST_FIRE: begin
        if (walk_end) begin
          cur_d   = active_head_q;
          prev_d  = stpool_pkg::NULL_LINK;
          steps_d = '0;
        end else if (!fire || out_free) begin
          // a firing slot waits here until the output register is free
          elap_we   = 1'b1;
          elap_wd   = fire ? '0 : sat;
          cur_d     = link_rd;
          steps_d   = steps_q + LW'(1);
          push      = fire;
          push_last = 1'b0;
          push_kind = stpool_pkg::KIND_FIRED;
          push_slot = stpool_pkg::SLOT_FIELD_W'(cur_idx);
          push_tag  = tag_q[cur_idx];
          push_ival = ival_q[cur_idx];
          push_elap = sat;
        end
      end
      stpool_pkg::ST_PRUNE: begin
        if (!walk_end) begin
          if (!active_q[cur_idx]) begin
            // unlink here, push onto the free list next cycle
            next_d = link_rd;
            if (prev_q == stpool_pkg::NULL_LINK) begin
              active_head_d = link_rd;
            end else begin
              link_we = 1'b1;
              link_wa = prev_q[SW-1:0];
              link_wd = link_rd;
            end
          end else begin
            prev_d  = cur_q;
            cur_d   = link_rd;
            steps_d = steps_q + LW'(1);
          end
        end
      end
      stpool_pkg::ST_FREE: begin
        link_we     = 1'b1;
        link_wa     = cur_idx;
        link_wd     = free_head_q;
        free_head_d = cur_q;
        cur_d       = next_q;
        steps_d     = steps_q + LW'(1);
      end
      stpool_pkg::ST_RESP: begin
        push = out_free;
      end
      stpool_pkg::ST_DONE: begin
        push      = out_free;
        push_kind = stpool_pkg::KIND_TICK_DONE;
        push_slot = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= stpool_pkg::ST_IDLE;
      free_head_q   <= '0;
      active_head_q <= stpool_pkg::NULL_LINK;
      cur_q         <= stpool_pkg::NULL_LINK;
      prev_q        <= stpool_pkg::NULL_LINK;
      next_q        <= stpool_pkg::NULL_LINK;
      steps_q       <= '0;
      kind_q        <= stpool_pkg::KIND_ALLOC;
      rslot_q       <= '0;
      active_q      <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < SC; i++) begin
        link_q[i] <= LW'(i + 1);
      end
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      cur_q         <= cur_d;
      prev_q        <= prev_d;
      next_q        <= next_d;
      steps_q       <= steps_d;
      kind_q        <= kind_d;
      rslot_q       <= rslot_d;
      if (link_we) link_q[link_wa] <= link_wd;
      if (act_set) active_q[free_head_q[SW-1:0]] <= 1'b1;
      if (act_clr) active_q[act_clr_idx] <= 1'b0;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_ival_q <= in_ival;
      req_tag_q  <= in_tag;
      req_tick_q <= in_tick;
    end
    if (alloc_we) begin
      ival_q[free_head_q[SW-1:0]] <= req_ival_q;
      tag_q[free_head_q[SW-1:0]]  <= req_tag_q;
    end
    if (elap_we) elap_q[elap_wa] <= elap_wd;
    if (push) begin
      out_data_q <= {1'b0, push_elap, push_ival, push_tag, push_slot, push_kind};
      out_last_q <= push_last;
    end
  end

  // the slot at the free head is never live and never on the active list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q != stpool_pkg::NULL_LINK |-> !active_q[free_head_q[SW-1:0]])
    else $error("free head slot is marked active");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q != stpool_pkg::NULL_LINK |-> free_head_q != active_head_q)
    else $error("slot heads both lists");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op == stpool_pkg::OP_TICK |=> state_q == stpool_pkg::ST_FIRE)
    else $error("tick request did not start the fire walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == stpool_pkg::KIND_FIRED |-> !m_axis_tlast)
    else $error("fired result marked last");

endmodule

>>> tb/sv/software_timer_pool_test.sv
// Self-checking testbench for the timer pool: request stream, predictor and result scoreboard.
module software_timer_pool_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_REQS = 450;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]                    op;
    logic [stpool_pkg::IVAL_W-1:0] ival;
    logic [stpool_pkg::TAG_W-1:0]  tag;
    logic [stpool_pkg::TICK_W-1:0] tick;
    logic [3:0]                    target;
  } request_t;

  typedef struct {
    stpool_pkg::kind_e             kind;
    logic [3:0]                    slot;
    logic [stpool_pkg::TAG_W-1:0]  tag;
    logic [stpool_pkg::IVAL_W-1:0] ival;
    logic [stpool_pkg::ELAP_W-1:0] elap;
    logic                          last;
  } result_t;

  // directed stimulus; typed rows carry their single expected result
  typedef struct {
    logic [1:0]                    op;
    logic [stpool_pkg::IVAL_W-1:0] ival;
    logic [stpool_pkg::TAG_W-1:0]  tag;
    logic [stpool_pkg::TICK_W-1:0] tick;
    logic [3:0]                    target;
    int                            reps;
    bit                            typed;
    stpool_pkg::kind_e             lit_kind;
    logic [3:0]                    lit_slot;
  } plan_row_t;

  localparam int PLAN_ROWS = 17;

  plan_row_t plan [PLAN_ROWS] = '{
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_TICK_DONE,  4'd0},
    '{stpool_pkg::OP_ALLOC,  32'd0,         16'hFFFF, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_ALLOC,  32'hFFFF_FFFF, 16'h0000, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_ALLOC,      4'd1},
    '{stpool_pkg::OP_ALLOC,  32'd100,       16'h1234, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_ALLOC,      4'd2},
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'hFFFF, 4'd0,  1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'd0,    4'd0,  1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_CANCEL, 32'd0,         16'h0000, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_CANCEL_ACK, 4'd0},
    '{stpool_pkg::OP_CANCEL, 32'd0,         16'h0000, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_CANCEL_ACK, 4'd0},
    '{stpool_pkg::OP_CANCEL, 32'd0,         16'h0000, 16'd0,    4'd15, 1,  1'b1,
      stpool_pkg::KIND_CANCEL_ACK, 4'd0},
    '{OP_UNUSED,             32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'd50,   4'd0,  1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_ALLOC,  32'd7,         16'hABCD, 16'd0,    4'd0,  14, 1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_ALLOC,  32'd5,         16'h5555, 16'd0,    4'd0,  1,  1'b1,
      stpool_pkg::KIND_EMPTY,      4'd0},
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'hFFFF, 4'd0,  1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0},
    '{stpool_pkg::OP_CANCEL, 32'd0,         16'h0000, 16'd0,    4'd1,  1,  1'b1,
      stpool_pkg::KIND_CANCEL_ACK, 4'd0},
    '{stpool_pkg::OP_CANCEL, 32'd0,         16'h0000, 16'd0,    4'd2,  1,  1'b1,
      stpool_pkg::KIND_CANCEL_ACK, 4'd0},
    '{stpool_pkg::OP_TICK,   32'd0,         16'h0000, 16'd1,    4'd0,  1,  1'b0,
      stpool_pkg::KIND_ALLOC,      4'd0}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [stpool_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [stpool_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tlast;

  // predictor copy of the pool
  logic [stpool_pkg::LINK_W-1:0] pool_next [stpool_pkg::SLOT_COUNT];
  logic                          pool_live [stpool_pkg::SLOT_COUNT];
  logic [stpool_pkg::IVAL_W-1:0] pool_ival [stpool_pkg::SLOT_COUNT];
  logic [stpool_pkg::ELAP_W-1:0] pool_elap [stpool_pkg::SLOT_COUNT];
  logic [stpool_pkg::TAG_W-1:0]  pool_tag  [stpool_pkg::SLOT_COUNT];
  logic [stpool_pkg::LINK_W-1:0] pool_free_head;
  logic [stpool_pkg::LINK_W-1:0] pool_active_head;

  result_t step_results [$];
  result_t awaited_results [$];

  int failures = 0;
  int results_seen = 0;
  bit calm = 1'b0;

  software_timer_pool dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void pool_clear();
    for (int i = 0; i < stpool_pkg::SLOT_COUNT; i++) begin
      pool_next[i] = stpool_pkg::LINK_W'(i + 1);
      pool_live[i] = 1'b0;
      pool_ival[i] = '0;
      pool_elap[i] = '0;
      pool_tag[i]  = '0;
    end
    pool_free_head   = '0;
    pool_active_head = stpool_pkg::NULL_LINK;
  endfunction

  function automatic void emit(stpool_pkg::kind_e k, logic [3:0] s,
                               logic [stpool_pkg::TAG_W-1:0] t,
                               logic [stpool_pkg::IVAL_W-1:0] iv,
                               logic [stpool_pkg::ELAP_W-1:0] el, logic lst);
    result_t res;
    res.kind = k;
    res.slot = s;
    res.tag  = t;
    res.ival = iv;
    res.elap = el;
    res.last = lst;
    step_results.push_back(res);
  endfunction

  // applies one request to the pool copy and leaves its results in step_results
  function automatic void pool_apply(request_t r);
    logic [stpool_pkg::LINK_W-1:0] cur, prv, nxt, s;
    logic [stpool_pkg::ELAP_W-1:0] e, add;
    int steps;
    step_results.delete();
    case (r.op)
      stpool_pkg::OP_ALLOC: begin
        s = pool_free_head;
        if (s == stpool_pkg::NULL_LINK) begin
          emit(stpool_pkg::KIND_EMPTY, 4'd0, '0, '0, '0, 1'b1);
        end else begin
          pool_free_head   = pool_next[s];
          pool_ival[s]     = r.ival;
          pool_tag[s]      = r.tag;
          pool_elap[s]     = '0;
          pool_live[s]     = 1'b1;
          pool_next[s]     = pool_active_head;
          pool_active_head = s;
          emit(stpool_pkg::KIND_ALLOC, s[3:0], '0, '0, '0, 1'b1);
        end
      end
      stpool_pkg::OP_TICK: begin
        add = stpool_pkg::ELAP_W'(r.tick);
        cur = pool_active_head;
        steps = 0;
        while (cur != stpool_pkg::NULL_LINK && steps < stpool_pkg::SLOT_COUNT) begin
          e = (pool_elap[cur] > ('1 - add)) ? '1 : pool_elap[cur] + add;
          pool_elap[cur] = e;
          if (e >= pool_ival[cur]) begin
            emit(stpool_pkg::KIND_FIRED, cur[3:0], pool_tag[cur], pool_ival[cur], e, 1'b0);
            pool_elap[cur] = '0;
          end
          cur = pool_next[cur];
          steps++;
        end
        // unlink cancelled slots onto the free list
        cur = pool_active_head;
        prv = stpool_pkg::NULL_LINK;
        steps = 0;
        while (cur != stpool_pkg::NULL_LINK && steps < stpool_pkg::SLOT_COUNT) begin
          nxt = pool_next[cur];
          if (!pool_live[cur]) begin
            if (prv == stpool_pkg::NULL_LINK) pool_active_head = nxt;
            else pool_next[prv] = nxt;
            pool_next[cur] = pool_free_head;
            pool_free_head = cur;
          end else begin
            prv = cur;
          end
          cur = nxt;
          steps++;
        end
        emit(stpool_pkg::KIND_TICK_DONE, 4'd0, '0, '0, '0, 1'b1);
      end
      stpool_pkg::OP_CANCEL: begin
        pool_live[r.target] = 1'b0;
        emit(stpool_pkg::KIND_CANCEL_ACK, 4'd0, '0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(request_t r, bit typed, stpool_pkg::kind_e lit_kind,
                              logic [3:0] lit_slot);
    result_t lit;
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {2'b00, r.target, r.tick, r.tag, r.ival, r.op};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pool_apply(r);
    if (typed) begin
      lit.kind = lit_kind;
      lit.slot = lit_slot;
      lit.tag  = '0;
      lit.ival = '0;
      lit.elap = '0;
      lit.last = 1'b1;
      awaited_results.push_back(lit);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    @(negedge clk_i);
  endtask

  function automatic logic [3:0] pick_target();
    logic [3:0] live_slots [$];
    for (int i = 0; i < stpool_pkg::SLOT_COUNT; i++)
      if (pool_live[i]) live_slots.push_back(4'(i));
    if (live_slots.size() == 0 || $urandom_range(99) < 20) return 4'($urandom_range(15));
    return live_slots[$urandom_range(live_slots.size() - 1)];
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endfunction

  // result scoreboard
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d", m_axis_tdata[2:0], m_axis_tdata[6:3]);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(m_axis_tdata[2:0]));
        check_field("slot", 32'(want.slot), 32'(m_axis_tdata[6:3]));
        check_field("tag", 32'(want.tag), 32'(m_axis_tdata[22:7]));
        check_field("fired_interval", want.ival, m_axis_tdata[54:23]);
        check_field("fired_elapsed", want.elap, m_axis_tdata[86:55]);
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (!held && results_seen >= 120) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = calm || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    request_t r;
    int counted, alloc_w, cancel_w, roll;
    counted = 0;
    alloc_w = 40;
    cancel_w = 25;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    pool_clear();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        r.op     = plan[i].op;
        r.ival   = plan[i].ival;
        r.tag    = plan[i].tag;
        r.tick   = plan[i].tick;
        r.target = plan[i].target;
        send_request(r, plan[i].typed, plan[i].lit_kind, plan[i].lit_slot);
      end
    end

    while (counted < RANDOM_REQS) begin
      if (counted % 50 == 0) begin
        alloc_w  = $urandom_range(25, 55);
        cancel_w = $urandom_range(10, 35);
      end
      calm = (counted >= 200 && counted < 260);
      r.tag    = 16'($urandom_range(16'hFFFF));
      r.target = 4'($urandom_range(15));
      case ($urandom_range(9))
        0:          r.ival = '0;
        1, 2, 3, 4: r.ival = $urandom_range(1, 1500);
        5, 6:       r.ival = $urandom_range(0, 65535);
        7:          r.ival = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        default:    r.ival = $urandom;
      endcase
      case ($urandom_range(9))
        0:       r.tick = '0;
        8:       r.tick = 16'($urandom_range(16'hFFFF));
        9:       r.tick = 16'hFFFF;
        default: r.tick = 16'($urandom_range(1, 400));
      endcase
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) begin
        r.op = OP_UNUSED;
      end else if (roll < alloc_w) begin
        r.op = stpool_pkg::OP_ALLOC;
      end else if (roll < alloc_w + cancel_w) begin
        r.op = stpool_pkg::OP_CANCEL;
        r.target = pick_target();
      end else begin
        r.op = stpool_pkg::OP_TICK;
      end
      send_request(r, 1'b0, stpool_pkg::KIND_ALLOC, 4'd0);
      if (r.op != OP_UNUSED) counted++;
    end
    calm = 1'b0;
    s_axis_tvalid = 1'b0;

    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
